### src/first_fit_heap_allocator_macros.svh
// Assertion macros used by the heap allocator engine.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ffha_pkg.sv
// Shared types and codes of the heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  localparam int GRAIN_BYTES = 8;
  localparam int MIN_GRANS   = 2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] request_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [31:0] address_out;
    logic [12:0] copy_bytes;
    logic [1:0]  status;
  } rsp_t;

endpackage

### src/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with header RAM, geometry and sequencer.
// Usage:
//   Configuration: cfg_we writes cfg_wdata into heap_base (cfg_idx 0) or
//   heap_bytes (cfg_idx 1); each write rebuilds the heap as one free block,
//   and in_ready stays low until the rebuild is done. Write only idle.
//   Input channel in_valid/in_ready/in_data carries allocate, free or
//   reallocate beats; output channel out_valid/out_ready/out_data returns
//   exactly one result beat per input beat, in order.
//   Per operation: the first-fit walk reads one block header at a time and
//   may split the found block; a free coalesces with free neighbours; a
//   moving reallocate checks the size, allocates, then frees the old block.
//   The walk is bound by the single read port of the header RAM.
//   One item is in work at a time; in_ready is low until its result is
//   registered. A stalled receiver holds the result in the output register;
//   the next beat may be accepted meanwhile, but its result waits for it.
//   Reset clears the heap configuration (heap not set up: all operations
//   answer ignored); header RAM contents are undefined until written.
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
  parameter int HEAP_GRANULES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_idx,
  input  logic [31:0]    cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffha_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ffha_pkg::rsp_t out_data
);
  import ffha_pkg::*;

  localparam int SW = $clog2(HEAP_GRANULES + 1);
  localparam int GI = $clog2(HEAP_GRANULES);
  localparam int HW = 2 * SW + 1;

  logic [31:0]   abase;
  logic [SW-1:0] ngran;
  logic          heap_ready, busy, init_we;
  logic [HW-1:0] init_wdata;
  logic          rd_en, eng_we, ram_we;
  logic [GI-1:0] rd_addr, eng_waddr, ram_waddr;
  logic [HW-1:0] rd_data, eng_wdata, ram_wdata;

  ffha_geom #(.HEAP_GRANULES(HEAP_GRANULES)) u_geom (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .abase(abase), .ngran(ngran), .heap_ready(heap_ready), .busy(busy),
    .init_we(init_we), .init_wdata(init_wdata)
  );

  assign ram_we    = init_we || eng_we;
  assign ram_waddr = init_we ? '0 : eng_waddr;
  assign ram_wdata = init_we ? init_wdata : eng_wdata;

  ffha_ram #(.WIDTH(HW), .DEPTH(HEAP_GRANULES)) u_hdr_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_data)
  );

  ffha_engine #(.HEAP_GRANULES(HEAP_GRANULES)) u_engine (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .abase(abase), .ngran(ngran), .heap_ready(heap_ready), .busy(busy),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(eng_we), .wr_addr(eng_waddr), .wr_data(eng_wdata)
  );
endmodule

### src/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### src/ffha_geom.sv
// Heap configuration registers and heap geometry rebuild.
`timescale 1ns / 1ps
module ffha_geom #(
  parameter int HEAP_GRANULES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_idx,
  input  logic [31:0]                          cfg_wdata,
  output logic [31:0]                          abase,
  output logic [$clog2(HEAP_GRANULES+1)-1:0]   ngran,
  output logic                                 heap_ready,
  output logic                                 busy,
  output logic                                 init_we,
  output logic [2*$clog2(HEAP_GRANULES+1):0]   init_wdata
);
  import ffha_pkg::*;

  localparam int SW = $clog2(HEAP_GRANULES + 1);
  localparam int MAXB = HEAP_GRANULES * GRAIN_BYTES;
  localparam logic [20:0] MAXB_W = MAXB[20:0];

  logic [31:0] heap_base;
  logic [13:0] heap_bytes;
  logic        pend;

  logic [32:0] abase_w;
  logic [2:0]  slack;
  logic [20:0] bytes_c;
  logic [20:0] bytes_a;
  logic [32:0] tail;
  logic [20:0] bytes_f;
  logic [SW-1:0] ngran_w;

  always_comb begin
    abase_w = ({1'b0, heap_base} + 33'd7) & ~33'd7;
    slack   = 3'd0 - heap_base[2:0];
    bytes_c = ({7'd0, heap_bytes} > MAXB_W) ? MAXB_W : {7'd0, heap_bytes};
    bytes_a = (bytes_c > {18'd0, slack}) ?
              ((bytes_c - {18'd0, slack}) & ~21'd7) : 21'd0;
    tail    = 33'h1_0000_0000 - abase_w;
    if (abase_w[32]) begin
      bytes_f = 21'd0;
    end else if ({12'd0, bytes_a} > tail) begin
      bytes_f = tail[20:0];
    end else begin
      bytes_f = bytes_a;
    end
    ngran_w = bytes_f[SW+2:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= 32'd0;
      heap_bytes <= 14'd0;
      pend       <= 1'b0;
      abase      <= 32'd0;
      ngran      <= '0;
      heap_ready <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_HEAP_BASE) begin
          heap_base <= cfg_wdata;
        end else begin
          heap_bytes <= cfg_wdata[13:0];
        end
        pend <= 1'b1;
      end else if (pend) begin
        pend       <= 1'b0;
        abase      <= abase_w[31:0];
        ngran      <= ngran_w;
        heap_ready <= (heap_bytes != 14'd0);
      end
    end
  end

  // one free block spanning the whole heap
  assign init_we    = pend && !cfg_we && (heap_bytes != 14'd0) && (ngran_w != '0);
  assign init_wdata = {ngran_w, 1'b0, {SW{1'b0}}};
  assign busy       = pend;
endmodule

### src/ffha_engine.sv
// Allocation sequencer: first-fit walk, split, free, coalesce and reallocate over the header RAM.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_macros.svh"
module ffha_engine #(
  parameter int HEAP_GRANULES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ffha_pkg::req_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ffha_pkg::rsp_t                       out_data,
  input  logic [31:0]                          abase,
  input  logic [$clog2(HEAP_GRANULES+1)-1:0]   ngran,
  input  logic                                 heap_ready,
  input  logic                                 busy,
  output logic                                 rd_en,
  output logic [$clog2(HEAP_GRANULES)-1:0]     rd_addr,
  input  logic [2*$clog2(HEAP_GRANULES+1):0]   rd_data,
  output logic                                 wr_en,
  output logic [$clog2(HEAP_GRANULES)-1:0]     wr_addr,
  output logic [2*$clog2(HEAP_GRANULES+1):0]   wr_data
);
  import ffha_pkg::*;

  localparam int SW = $clog2(HEAP_GRANULES + 1);
  localparam int GI = $clog2(HEAP_GRANULES);
  localparam int HW = 2 * SW + 1;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DEC    = 5'd1;
  localparam logic [4:0] S_A_INIT = 5'd2;
  localparam logic [4:0] S_A_CHK  = 5'd3;
  localparam logic [4:0] S_A_EVAL = 5'd4;
  localparam logic [4:0] S_A_SPL2 = 5'd5;
  localparam logic [4:0] S_A_AFT  = 5'd6;
  localparam logic [4:0] S_A_DONE = 5'd7;
  localparam logic [4:0] S_FB_RD  = 5'd8;
  localparam logic [4:0] S_FB_EV  = 5'd9;
  localparam logic [4:0] S_FB_NX  = 5'd10;
  localparam logic [4:0] S_FB_AF1 = 5'd11;
  localparam logic [4:0] S_FB_PV  = 5'd12;
  localparam logic [4:0] S_FB_PG  = 5'd13;
  localparam logic [4:0] S_FB_AF2 = 5'd14;
  localparam logic [4:0] S_RE_RD  = 5'd15;
  localparam logic [4:0] S_RE_EV  = 5'd16;
  localparam logic [4:0] S_RESP   = 5'd17;

  logic [4:0]    state;
  req_t          req;
  logic [SW-1:0] g, fg, pg, aft, bsr, hsz, hprv, cur;
  logic [29:0]   need;
  logic          moving;
  logic [31:0]   res;
  logic [12:0]   copy;
  logic [1:0]    st;

  logic [SW-1:0] h_size, h_prev;
  logic          h_used;
  logic [SW-1:0] rs_at, rs_lim, rs_out;
  logic [29:0]   need_raw, need_min;
  logic [33:0]   loc_lo;
  logic [31:0]   loc_off;
  logic          loc_ok, free_ok;
  logic [SW-1:0] loc_g, n_gr, sum_fb, nx_fb, mrg_lim, merged, g_fit;
  logic [SW:0]   mrg_raw;
  logic [SW+2:0] cur_bytes;
  logic [12:0]   copy_w;

  assign h_size = rd_data[HW-1 -: SW];
  assign h_used = rd_data[SW];
  assign h_prev = rd_data[SW-1:0];

  // shared clamp unit: block size limited to the heap end
  assign rs_lim = ngran - rs_at;
  assign rs_out = (h_size < rs_lim) ? h_size : rs_lim;

  assign need_raw = 30'(({1'b0, req.request_size} + 33'd15) >> 3);
  assign need_min = (need_raw < 30'(MIN_GRANS)) ? 30'(MIN_GRANS) : need_raw;
  assign n_gr     = need[SW-1:0];

  assign loc_lo  = {2'b0, abase} + 34'd8;
  assign loc_off = req.address - abase - 32'd8;
  assign loc_g   = loc_off[SW+2:3];
  assign loc_ok  = ({2'b0, req.address} >= loc_lo) && (loc_off[2:0] == 3'd0) &&
                   (loc_off[31:3] < {{(29-SW){1'b0}}, ngran});
  assign free_ok = heap_ready && (req.address != 32'd0) && loc_ok;

  assign sum_fb  = bsr + rs_out;
  assign nx_fb   = fg + rs_out;
  assign mrg_lim = ngran - pg;
  assign mrg_raw = {1'b0, h_size} + {1'b0, bsr};
  assign merged  = (mrg_raw > {1'b0, mrg_lim}) ? mrg_lim : mrg_raw[SW-1:0];
  assign g_fit   = g + n_gr;

  assign cur_bytes = (cur != '0) ? ({cur, 3'b000} - (SW+3)'(GRAIN_BYTES)) : '0;
  assign copy_w    = ({{(29-SW){1'b0}}, cur_bytes} > req.request_size) ?
                     req.request_size[12:0] : cur_bytes[12:0];

  assign in_ready = (state == S_IDLE) && !busy;

  always_comb begin
    rs_at   = g;
    rd_en   = 1'b0;
    rd_addr = g[GI-1:0];
    wr_en   = 1'b0;
    wr_addr = g[GI-1:0];
    wr_data = rd_data;
    case (state)
      S_A_CHK: begin
        rd_en = (g < ngran);
      end
      S_A_EVAL: begin
        if (rs_out != '0 && !h_used && {{(30-SW){1'b0}}, rs_out} >= need) begin
          wr_en = 1'b1;
          if ({{(30-SW){1'b0}}, rs_out} >= need + 30'(MIN_GRANS)) begin
            wr_addr = g_fit[GI-1:0];
            wr_data = {rs_out - n_gr, 1'b0, n_gr};
          end else begin
            wr_data = {h_size, 1'b1, h_prev};
          end
        end
      end
      S_A_SPL2: begin
        wr_en   = 1'b1;
        wr_data = {n_gr, 1'b1, hprv};
        rd_en   = (aft < ngran);
        rd_addr = aft[GI-1:0];
      end
      S_A_AFT, S_FB_AF1, S_FB_AF2: begin
        wr_en   = 1'b1;
        wr_addr = aft[GI-1:0];
        wr_data = {h_size, h_used, (state == S_A_AFT) ? hsz : bsr};
      end
      S_FB_RD: begin
        rd_en   = 1'b1;
        rd_addr = fg[GI-1:0];
      end
      S_FB_EV: begin
        rs_at   = fg;
        rd_addr = nx_fb[GI-1:0];
        wr_addr = fg[GI-1:0];
        wr_data = {h_size, 1'b0, h_prev};
        if (nx_fb < ngran) begin
          rd_en = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_FB_NX: begin
        rs_at   = aft;
        wr_en   = 1'b1;
        wr_addr = fg[GI-1:0];
        rd_addr = GI'(fg + sum_fb);
        if (!h_used) begin
          wr_data = {sum_fb, 1'b0, hprv};
          rd_en   = ((fg + sum_fb) < ngran);
        end else begin
          wr_data = {hsz, 1'b0, hprv};
        end
      end
      S_FB_PV: begin
        rd_addr = GI'(fg - hprv);
        rd_en   = (hprv != '0) && (hprv <= fg);
      end
      S_FB_PG: begin
        rs_at   = pg;
        wr_addr = pg[GI-1:0];
        wr_data = {merged, 1'b0, h_prev};
        rd_addr = GI'(pg + merged);
        if (!h_used) begin
          wr_en = 1'b1;
          rd_en = ((pg + merged) < ngran);
        end
      end
      S_RE_RD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      moving    <= 1'b0;
    end else begin
      // S_RESP reloads the slot itself
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req    <= in_data;
            moving <= 1'b0;
            copy   <= 13'd0;
            res    <= 32'd0;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          case (req.operation)
            OP_ALLOC: begin
              state <= S_A_INIT;
            end
            OP_FREE: begin
              if (free_ok) begin
                fg    <= loc_g;
                st    <= ST_DONE;
                state <= S_FB_RD;
              end else begin
                st    <= ST_IGNORED;
                state <= S_RESP;
              end
            end
            OP_REALLOC: begin
              if (req.address == 32'd0) begin
                state <= S_A_INIT;
              end else if (req.request_size == 32'd0 && free_ok) begin
                fg    <= loc_g;
                st    <= ST_DONE;
                state <= S_FB_RD;
              end else if (req.request_size != 32'd0 && free_ok) begin
                g     <= loc_g;
                state <= S_RE_RD;
              end else begin
                st    <= ST_IGNORED;
                state <= S_RESP;
              end
            end
            default: begin
              st    <= ST_IGNORED;
              state <= S_RESP;
            end
          endcase
        end
        S_A_INIT: begin
          if (!heap_ready || req.request_size == 32'd0) begin
            st    <= ST_IGNORED;
            state <= S_RESP;
          end else begin
            need  <= need_min;
            g     <= '0;
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (g < ngran) begin
            state <= S_A_EVAL;
          end else begin
            st    <= ST_NOFIT;
            state <= S_RESP;
          end
        end
        S_A_EVAL: begin
          if (rs_out == '0) begin
            st    <= ST_NOFIT;
            state <= S_RESP;
          end else if (!h_used && {{(30-SW){1'b0}}, rs_out} >= need) begin
            hprv <= h_prev;
            if ({{(30-SW){1'b0}}, rs_out} >= need + 30'(MIN_GRANS)) begin
              aft   <= g + rs_out;
              hsz   <= rs_out - n_gr;
              state <= S_A_SPL2;
            end else begin
              state <= S_A_DONE;
            end
          end else begin
            g     <= g + rs_out;
            state <= S_A_CHK;
          end
        end
        S_A_SPL2: begin
          state <= (aft < ngran) ? S_A_AFT : S_A_DONE;
        end
        S_A_AFT: begin
          state <= S_A_DONE;
        end
        S_A_DONE: begin
          res <= abase + {{(29-SW){1'b0}}, g, 3'b000} + 32'd8;
          st  <= ST_DONE;
          if (moving) begin
            copy  <= copy_w;
            state <= S_FB_RD;
          end else begin
            state <= S_RESP;
          end
        end
        S_FB_RD: begin
          state <= S_FB_EV;
        end
        S_FB_EV: begin
          hsz  <= h_size;
          hprv <= h_prev;
          bsr  <= rs_out;
          aft  <= nx_fb;
          state <= (nx_fb < ngran) ? S_FB_NX : S_FB_PV;
        end
        S_FB_NX: begin
          if (!h_used) begin
            bsr   <= sum_fb;
            aft   <= fg + sum_fb;
            state <= ((fg + sum_fb) < ngran) ? S_FB_AF1 : S_FB_PV;
          end else begin
            state <= S_FB_PV;
          end
        end
        S_FB_AF1: begin
          state <= S_FB_PV;
        end
        S_FB_PV: begin
          pg    <= fg - hprv;
          state <= (hprv != '0 && hprv <= fg) ? S_FB_PG : S_RESP;
        end
        S_FB_PG: begin
          if (!h_used) begin
            bsr   <= merged;
            aft   <= pg + merged;
            state <= ((pg + merged) < ngran) ? S_FB_AF2 : S_RESP;
          end else begin
            state <= S_RESP;
          end
        end
        S_FB_AF2: begin
          state <= S_RESP;
        end
        S_RE_RD: begin
          state <= S_RE_EV;
        end
        S_RE_EV: begin
          cur <= rs_out;
          if (need_raw <= {{(30-SW){1'b0}}, rs_out}) begin
            res   <= req.address;
            st    <= ST_DONE;
            state <= S_RESP;
          end else begin
            fg     <= g;
            moving <= 1'b1;
            state  <= S_A_INIT;
          end
        end
        S_RESP: begin
          // hold until the output slot is free
          if (!out_valid || out_ready) begin
            out_data  <= '{address_out: res, copy_bytes: copy, status: st};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFHA_ASSERT_NOW(a_cfg_idle, busy && state != S_IDLE, 1'b0,
                   "heap rebuild overlaps an operation")
  `FFHA_ASSERT_NEXT(a_accept_dec, in_valid && in_ready, state == S_DEC,
                    "accepted beat not decoded next cycle")
  `FFHA_ASSERT_NOW(a_walk_range, state == S_A_EVAL, g < ngran,
                   "first-fit walk ran past the heap end")
  `FFHA_ASSERT_NOW(a_nofit_null, out_valid && out_data.status == ST_NOFIT,
                   out_data.address_out == 32'd0 && out_data.copy_bytes == 13'd0,
                   "failed allocation returned a pointer")
  `FFHA_ASSERT_NOW(a_copy_done, out_valid && out_data.copy_bytes != 13'd0,
                   out_data.status == ST_DONE,
                   "copy length reported without success")
endmodule
